// File: rtl/core/bhi_pkg.sv
// Shared types for the barycentric height interpolation core.
// No dependencies; imported by barycentric_height_interp_core.
package bhi_pkg;

    // Per-request flags that ride along the divider and back-end stages.
    typedef struct packed {
        logic deg;   // determinant is zero
        logic neg1;  // first weight is negative
        logic neg2;  // second weight is negative
    } t_flags;

endpackage

// File: rtl/core/barycentric_height_interp_core.sv
// Barycentric height interpolation core: fixed-point triangle interpolation pipeline.
// Depends on bhi_pkg (t_flags).

// Takes one request per cycle while the output is not stalled: three triangle
// vertices (x, height, z) and a query point (x, z), all signed fixed point with
// FRAC_BITS fraction bits. It returns the interpolated height, truncated toward
// zero and saturated, or zero with the degenerate flag set when the triangle has
// zero area in the x-z plane. The two weight divisions use restoring dividers
// that retire one quotient bit per stage. Throughput is one request per cycle
// unless the output stalls. A stall on the output freezes the whole pipeline;
// o_stall is high only while a result waits.
module barycentric_height_interp_core #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_p1_x,
    input  logic signed [COORD_WIDTH-1:0] i_p1_y,
    input  logic signed [COORD_WIDTH-1:0] i_p1_z,
    input  logic signed [COORD_WIDTH-1:0] i_p2_x,
    input  logic signed [COORD_WIDTH-1:0] i_p2_y,
    input  logic signed [COORD_WIDTH-1:0] i_p2_z,
    input  logic signed [COORD_WIDTH-1:0] i_p3_x,
    input  logic signed [COORD_WIDTH-1:0] i_p3_y,
    input  logic signed [COORD_WIDTH-1:0] i_p3_z,
    input  logic signed [COORD_WIDTH-1:0] i_query_x,
    input  logic signed [COORD_WIDTH-1:0] i_query_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0] o_height,
    output logic                          o_degenerate
);
    import bhi_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int DW  = W + 1;                 // coordinate differences
    localparam int PW  = 2 * DW;                // difference products
    localparam int NW  = PW + 1;                // determinant and numerators
    localparam int QB  = NW - 1 + F;            // quotient magnitude bits
    localparam int LW  = QB + 1;                // signed weights
    localparam int CK  = W;                     // weight chunk for the multipliers
    localparam int NK  = (LW + CK - 1) / CK;
    localparam int LK  = NK * CK;
    localparam int PPW = CK + 1 + DW;
    localparam int AW  = QB + W + 3;            // weighted sum
    localparam int HW  = AW - F;

    typedef struct packed {
        t_flags                f;
        logic signed [W-1:0]   y3;
        logic signed [DW-1:0]  dy13;
        logic signed [DW-1:0]  dy23;
    } t_side;

    logic w_adv;
    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    // Stage 0: differences.
    logic                 r0_v;
    logic signed [DW-1:0] r0_dz23, r0_dx13, r0_dx32, r0_dz13, r0_dz31, r0_ex, r0_ez;
    logic signed [DW-1:0] r0_dy13, r0_dy23;
    logic signed [W-1:0]  r0_y3;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_dz23 <= DW'(i_p2_z) - DW'(i_p3_z);
            r0_dx13 <= DW'(i_p1_x) - DW'(i_p3_x);
            r0_dx32 <= DW'(i_p3_x) - DW'(i_p2_x);
            r0_dz13 <= DW'(i_p1_z) - DW'(i_p3_z);
            r0_dz31 <= DW'(i_p3_z) - DW'(i_p1_z);
            r0_ex   <= DW'(i_query_x) - DW'(i_p3_x);
            r0_ez   <= DW'(i_query_z) - DW'(i_p3_z);
            r0_dy13 <= DW'(i_p1_y) - DW'(i_p3_y);
            r0_dy23 <= DW'(i_p2_y) - DW'(i_p3_y);
            r0_y3   <= i_p3_y;
        end
    end

    // Stage 1: products.
    logic                 r1_v;
    logic signed [PW-1:0] r1_da, r1_db, r1_n1a, r1_n1b, r1_n2a, r1_n2b;
    logic signed [DW-1:0] r1_dy13, r1_dy23;
    logic signed [W-1:0]  r1_y3;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_da   <= r0_dz23 * r0_dx13;
            r1_db   <= r0_dx32 * r0_dz13;
            r1_n1a  <= r0_dz23 * r0_ex;
            r1_n1b  <= r0_dx32 * r0_ez;
            r1_n2a  <= r0_dz31 * r0_ex;
            r1_n2b  <= r0_dx13 * r0_ez;
            r1_dy13 <= r0_dy13;
            r1_dy23 <= r0_dy23;
            r1_y3   <= r0_y3;
        end
    end

    // Stage 2: determinant and numerators.
    logic                 r2_v;
    logic signed [NW-1:0] r2_det, r2_n1, r2_n2;
    logic signed [DW-1:0] r2_dy13, r2_dy23;
    logic signed [W-1:0]  r2_y3;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_det  <= NW'(r1_da) + NW'(r1_db);
            r2_n1   <= NW'(r1_n1a) + NW'(r1_n1b);
            r2_n2   <= NW'(r1_n2a) + NW'(r1_n2b);
            r2_dy13 <= r1_dy13;
            r2_dy23 <= r1_dy23;
            r2_y3   <= r1_y3;
        end
    end

    // Divider stages. Index 0 is loaded with magnitudes; each later stage
    // retires one quotient bit, shifted into the bottom of the dividend word.
    logic              r_dv_v [0:QB];
    logic [NW-2:0]     r_dv   [0:QB];
    logic [QB-1:0]     r_dq1  [0:QB];
    logic [QB-1:0]     r_dq2  [0:QB];
    logic [NW-1:0]     r_rm1  [0:QB];
    logic [NW-1:0]     r_rm2  [0:QB];
    t_side             r_sd   [0:QB];

    logic [NW-1:0] w_adet, w_an1, w_an2;
    assign w_adet = r2_det[NW-1] ? NW'(-r2_det) : NW'(r2_det);
    assign w_an1  = r2_n1[NW-1] ? NW'(-r2_n1) : NW'(r2_n1);
    assign w_an2  = r2_n2[NW-1] ? NW'(-r2_n2) : NW'(r2_n2);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv[0]      <= w_adet[NW-2:0];
            r_dq1[0]     <= {w_an1[NW-2:0], {F{1'b0}}};
            r_dq2[0]     <= {w_an2[NW-2:0], {F{1'b0}}};
            r_rm1[0]     <= '0;
            r_rm2[0]     <= '0;
            r_sd[0].f.deg  <= (r2_det == '0);
            r_sd[0].f.neg1 <= r2_n1[NW-1] ^ r2_det[NW-1];
            r_sd[0].f.neg2 <= r2_n2[NW-1] ^ r2_det[NW-1];
            r_sd[0].y3   <= r2_y3;
            r_sd[0].dy13 <= r2_dy13;
            r_sd[0].dy23 <= r2_dy23;
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_div
        logic [NW-1:0] w_t1, w_t2;
        logic          w_ge1, w_ge2;
        assign w_t1  = {r_rm1[k-1][NW-2:0], r_dq1[k-1][QB-1]};
        assign w_t2  = {r_rm2[k-1][NW-2:0], r_dq2[k-1][QB-1]};
        assign w_ge1 = (w_t1 >= {1'b0, r_dv[k-1]});
        assign w_ge2 = (w_t2 >= {1'b0, r_dv[k-1]});

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv[k]  <= r_dv[k-1];
                r_sd[k]  <= r_sd[k-1];
                r_rm1[k] <= w_ge1 ? (w_t1 - {1'b0, r_dv[k-1]}) : w_t1;
                r_rm2[k] <= w_ge2 ? (w_t2 - {1'b0, r_dv[k-1]}) : w_t2;
                r_dq1[k] <= {r_dq1[k-1][QB-2:0], w_ge1};
                r_dq2[k] <= {r_dq2[k-1][QB-2:0], w_ge2};
            end
        end
    end

    // Stage L: signed weights.
    logic                 rl_v;
    logic signed [LW-1:0] rl_l1, rl_l2;
    t_side                rl_sd;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            rl_l1 <= r_sd[QB].f.neg1 ? -$signed({1'b0, r_dq1[QB]}) : $signed({1'b0, r_dq1[QB]});
            rl_l2 <= r_sd[QB].f.neg2 ? -$signed({1'b0, r_dq2[QB]}) : $signed({1'b0, r_dq2[QB]});
            rl_sd <= r_sd[QB];
        end
    end

    // Stage M: chunked partial products of the weights with height differences.
    // All chunks but the top one are unsigned.
    logic                  rm_v;
    logic signed [PPW-1:0] rm_pp1 [NK];
    logic signed [PPW-1:0] rm_pp2 [NK];
    t_side                 rm_sd;
    logic signed [LK-1:0]  w_l1x, w_l2x;
    assign w_l1x = LK'(rl_l1);
    assign w_l2x = LK'(rl_l2);

    for (genvar k = 0; k < NK; k++) begin : g_pp
        logic signed [CK:0] w_c1, w_c2;
        if (k == NK - 1) begin : g_top
            assign w_c1 = {w_l1x[k*CK+CK-1], w_l1x[k*CK +: CK]};
            assign w_c2 = {w_l2x[k*CK+CK-1], w_l2x[k*CK +: CK]};
        end else begin : g_low
            assign w_c1 = {1'b0, w_l1x[k*CK +: CK]};
            assign w_c2 = {1'b0, w_l2x[k*CK +: CK]};
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                rm_pp1[k] <= w_c1 * rl_sd.dy13;
                rm_pp2[k] <= w_c2 * rl_sd.dy23;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            rm_sd <= rl_sd;
        end
    end

    // Stage P: recombine chunks.
    logic                 rp_v;
    logic signed [AW-1:0] rp_s1, rp_s2;
    t_side                rp_sd;
    logic signed [AW-1:0] w_s1, w_s2;

    always_comb begin
        w_s1 = '0;
        w_s2 = '0;
        for (int k = 0; k < NK; k++) begin
            w_s1 = w_s1 + (AW'(rm_pp1[k]) <<< (k * CK));
            w_s2 = w_s2 + (AW'(rm_pp2[k]) <<< (k * CK));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            rp_s1 <= w_s1;
            rp_s2 <= w_s2;
            rp_sd <= rm_sd;
        end
    end

    // Stage A: weighted sum; the third weight is folded into y3 scaled by one.
    logic                 ra_v;
    logic signed [AW-1:0] ra_acc;
    t_flags               ra_f;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            ra_acc <= rp_s1 + rp_s2 + (AW'(rp_sd.y3) <<< F);
            ra_f   <= rp_sd.f;
        end
    end

    // Stage H: divide by one, truncating toward zero.
    logic                 rh_v;
    logic signed [HW-1:0] rh_h;
    t_flags               rh_f;
    logic [AW-1:0]        w_bsum;
    assign w_bsum = ra_acc + $signed({{(AW-F){1'b0}}, {F{ra_acc[AW-1]}}});

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            rh_h <= w_bsum[AW-1:F];
            rh_f <= ra_f;
        end
    end

    // Output stage: saturation.
    logic w_ovf, w_unf;
    assign w_ovf = !rh_h[HW-1] && (|rh_h[HW-2:W-1]);
    assign w_unf = rh_h[HW-1] && !(&rh_h[HW-2:W-1]);

    logic                r_valid;
    logic signed [W-1:0] r_height;
    logic                r_deg;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_deg <= rh_f.deg;
            if (rh_f.deg) begin
                r_height <= '0;
            end else if (w_ovf) begin
                r_height <= {1'b0, {(W-1){1'b1}}};
            end else if (w_unf) begin
                r_height <= {1'b1, {(W-1){1'b0}}};
            end else begin
                r_height <= rh_h[W-1:0];
            end
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v    <= 1'b0;
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            rl_v    <= 1'b0;
            rm_v    <= 1'b0;
            rp_v    <= 1'b0;
            ra_v    <= 1'b0;
            rh_v    <= 1'b0;
            r_valid <= 1'b0;
            for (int k = 0; k <= QB; k++) begin
                r_dv_v[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r0_v      <= i_valid;
            r1_v      <= r0_v;
            r2_v      <= r1_v;
            r_dv_v[0] <= r2_v;
            for (int k = 1; k <= QB; k++) begin
                r_dv_v[k] <= r_dv_v[k-1];
            end
            rl_v    <= r_dv_v[QB];
            rm_v    <= rl_v;
            rp_v    <= rm_v;
            ra_v    <= rp_v;
            rh_v    <= ra_v;
            r_valid <= rh_v;
        end
    end

    assign o_valid      = r_valid;
    assign o_height     = r_height;
    assign o_degenerate = r_deg;

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_height == '0)
        else $error("degenerate result with nonzero height");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a waiting result");

endmodule
